/* design/stereo_downmix_biquad_dac_defines.svh */
// Assertion macros shared by the stereo downmix biquad DAC design files.
`ifndef STEREO_DOWNMIX_BIQUAD_DAC_DEFINES_SVH
`define STEREO_DOWNMIX_BIQUAD_DAC_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SDBD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SDBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/sdbd_pkg.sv */
// Shared types, constants and reset values of the stereo downmix biquad DAC.
`default_nettype none

package sdbd_pkg;

  // Field widths and fixed formats.
  localparam int SAMPLE_W   = 16;
  localparam int DAC_W      = 12;
  localparam int VOL_W      = 4;
  localparam int COEF_W     = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int STATE_FRAC = 8;
  localparam int SPLIT      = 24;
  localparam int DAC_SHIFT  = SAMPLE_W - DAC_W;

  // Default filter formats.
  localparam int COEF_FRAC_BITS_DEF = 20;
  localparam int STATE_WIDTH_DEF    = 40;

  // Shared multiplier operand and product widths.
  localparam int MUL_OP_W = 25;
  localparam int MUL_P_W  = 2 * MUL_OP_W;

  // Division by ten as a multiply by a reciprocal scaled by 2^DIV_SHIFT.
  localparam int MAG_W     = 20;
  localparam int Q_W       = 17;
  localparam int DIV_SHIFT = 27;
  localparam logic signed [MUL_OP_W-1:0] RECIP_TEN = MUL_OP_W'(13421773);

  localparam logic [DAC_W-1:0] DAC_MID = DAC_W'(2048);

  // Register reset values.
  localparam logic [VOL_W-1:0]         VOLUME_RST = VOL_W'(5);
  localparam logic                     BOOST_RST  = 1'b0;
  localparam logic signed [COEF_W-1:0] A0_RST     = COEF_W'(1053336);
  localparam logic signed [COEF_W-1:0] A1_RST     = COEF_W'(-2097152);
  localparam logic signed [COEF_W-1:0] A2_RST     = COEF_W'(1044295);
  localparam logic signed [COEF_W-1:0] B1_RST     = COEF_W'(-2071508);
  localparam logic signed [COEF_W-1:0] B2_RST     = COEF_W'(1023405);

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VOLUME = 3'd0,
    REG_BOOST  = 3'd1,
    REG_A0     = 3'd2,
    REG_A1     = 3'd3,
    REG_A2     = 3'd4,
    REG_B1     = 3'd5,
    REG_B2     = 3'd6
  } reg_idx_e;

  // Filter products in the order the sequencer runs them.
  typedef enum logic [2:0] {
    TERM_B1D1 = 3'd0,
    TERM_B2D2 = 3'd1,
    TERM_A1D1 = 3'd2,
    TERM_A2D2 = 3'd3,
    TERM_A0W  = 3'd4
  } term_e;

  // Operand selection of the shared multiplier.
  typedef enum logic [1:0] {
    MUL_VOL = 2'd0,
    MUL_DIV = 2'd1,
    MUL_LO  = 2'd2,
    MUL_HI  = 2'd3
  } mul_sel_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE  = 4'd0,
    ST_VOL   = 4'd1,
    ST_DIV   = 4'd2,
    ST_SCALE = 4'd3,
    ST_LO    = 4'd4,
    ST_HI    = 4'd5,
    ST_SUM   = 4'd6,
    ST_ACC   = 4'd7,
    ST_FIN   = 4'd8,
    ST_DONE  = 4'd9
  } state_e;

  // Configuration register contents.
  typedef struct packed {
    logic [VOL_W-1:0]         volume;
    logic                     boost;
    logic signed [COEF_W-1:0] a0;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
  } sdbd_cfg_t;

  // Control word from the sequencer to the datapath.
  typedef struct packed {
    logic     load_in;
    mul_sel_e mul_sel;
    term_e    term;
    logic     sign_cap;
    logic     scale_done;
    logic     prod_init;
    logic     prod_add;
    logic     acc_step;
    logic     acc_sub;
    logic     take_w;
    logic     finish;
    logic     out_load;
  } sdbd_ctrl_t;

endpackage

`default_nettype wire

/* design/sdbd_regs.sv */
// Configuration register file of the stereo downmix biquad DAC.
`default_nettype none

module sdbd_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [sdbd_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [sdbd_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output sdbd_pkg::sdbd_cfg_t              cfg_o
);
  import sdbd_pkg::*;

  sdbd_cfg_t cfg_q, cfg_d;
  logic      wr_en;

  // Writes are always taken.
  assign cfg_ready_o = 1'b1;
  assign wr_en       = cfg_valid_i && cfg_ready_o;

  // Decode the register index; unknown indexes leave everything unchanged.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (cfg_index_i)
        REG_VOLUME: cfg_d.volume = cfg_data_i[VOL_W-1:0];
        REG_BOOST:  cfg_d.boost  = cfg_data_i[0];
        REG_A0:     cfg_d.a0     = cfg_data_i[COEF_W-1:0];
        REG_A1:     cfg_d.a1     = cfg_data_i[COEF_W-1:0];
        REG_A2:     cfg_d.a2     = cfg_data_i[COEF_W-1:0];
        REG_B1:     cfg_d.b1     = cfg_data_i[COEF_W-1:0];
        REG_B2:     cfg_d.b2     = cfg_data_i[COEF_W-1:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.volume <= VOLUME_RST;
      cfg_q.boost  <= BOOST_RST;
      cfg_q.a0     <= A0_RST;
      cfg_q.a1     <= A1_RST;
      cfg_q.a2     <= A2_RST;
      cfg_q.b1     <= B1_RST;
      cfg_q.b2     <= B2_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* design/sdbd_mul.sv */
// Shared signed multiplier with a registered product.
`default_nettype none

module sdbd_mul (
  input  logic                                clk_i,
  input  logic signed [sdbd_pkg::MUL_OP_W-1:0] a_i,
  input  logic signed [sdbd_pkg::MUL_OP_W-1:0] b_i,
  output logic signed [sdbd_pkg::MUL_P_W-1:0]  p_o
);
  import sdbd_pkg::*;

  logic signed [MUL_P_W-1:0] p_q;

  // One full signed product per cycle.
  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

/* design/sdbd_seq.sv */
// Sequencer that steps one frame through the shared multiplier.
`default_nettype none

module sdbd_seq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  boost_i,
  input  logic                  out_free_i,
  output logic                  busy_o,
  output sdbd_pkg::sdbd_ctrl_t  ctrl_o
);
  import sdbd_pkg::*;

  state_e state_q, state_d;
  term_e  term_q, term_d;

  // Next state and product counter.
  always_comb begin
    state_d = state_q;
    term_d  = term_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_VOL;
      end
      ST_VOL:   state_d = ST_DIV;
      ST_DIV:   state_d = ST_SCALE;
      ST_SCALE: begin
        term_d  = TERM_B1D1;
        state_d = boost_i ? ST_LO : ST_DONE;
      end
      ST_LO:  state_d = ST_HI;
      ST_HI:  state_d = ST_SUM;
      ST_SUM: state_d = ST_ACC;
      ST_ACC: begin
        if (term_q == TERM_A0W) begin
          state_d = ST_FIN;
        end else begin
          term_d  = term_e'(term_q + 3'd1);
          state_d = ST_LO;
        end
      end
      ST_FIN: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control word for the datapath.
  always_comb begin
    ctrl_o            = '0;
    ctrl_o.mul_sel    = MUL_VOL;
    ctrl_o.term       = term_q;
    case (state_q)
      ST_IDLE:  ctrl_o.load_in = in_valid_i;
      ST_VOL:   ctrl_o.mul_sel = MUL_VOL;
      ST_DIV: begin
        ctrl_o.mul_sel  = MUL_DIV;
        ctrl_o.sign_cap = 1'b1;
      end
      ST_SCALE: ctrl_o.scale_done = 1'b1;
      ST_LO:    ctrl_o.mul_sel = MUL_LO;
      ST_HI: begin
        ctrl_o.mul_sel   = MUL_HI;
        ctrl_o.prod_init = 1'b1;
      end
      ST_SUM:   ctrl_o.prod_add = 1'b1;
      ST_ACC: begin
        case (term_q)
          TERM_B1D1: begin
            ctrl_o.acc_step = 1'b1;
            ctrl_o.acc_sub  = 1'b1;
          end
          TERM_B2D2: begin
            ctrl_o.take_w  = 1'b1;
            ctrl_o.acc_sub = 1'b1;
          end
          default:   ctrl_o.acc_step = 1'b1;
        endcase
      end
      ST_FIN:   ctrl_o.finish   = 1'b1;
      ST_DONE:  ctrl_o.out_load = out_free_i;
      default:  ctrl_o.load_in  = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      term_q  <= TERM_B1D1;
    end else begin
      state_q <= state_d;
      term_q  <= term_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

`default_nettype wire

/* design/sdbd_dp.sv */
// Datapath: downmix, volume scaling, biquad state and the DAC output register.
`default_nettype none
`include "stereo_downmix_biquad_dac_defines.svh"

module sdbd_dp #(
  parameter int COEF_FRAC_BITS = sdbd_pkg::COEF_FRAC_BITS_DEF,
  parameter int STATE_WIDTH    = sdbd_pkg::STATE_WIDTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  sdbd_pkg::sdbd_ctrl_t                 ctrl_i,
  input  sdbd_pkg::sdbd_cfg_t                  cfg_i,
  input  logic signed [sdbd_pkg::SAMPLE_W-1:0] left_i,
  input  logic signed [sdbd_pkg::SAMPLE_W-1:0] right_i,
  input  logic                                 dac_stall_i,
  output logic                                 dac_valid_o,
  output logic [sdbd_pkg::DAC_W-1:0]           dac_code_o,
  output logic                                 out_free_o,
  output logic signed [sdbd_pkg::MUL_OP_W-1:0] mul_a_o,
  output logic signed [sdbd_pkg::MUL_OP_W-1:0] mul_b_o,
  input  logic signed [sdbd_pkg::MUL_P_W-1:0]  mul_p_i
);
  import sdbd_pkg::*;

  localparam int PW   = STATE_WIDTH + SPLIT;
  localparam int AW   = PW + 2;
  localparam int ZH_W = STATE_WIDTH - SPLIT;

  logic signed [SAMPLE_W-1:0]    mean_q;
  logic signed [SAMPLE_W-1:0]    sample_q;
  logic                          sign_q;
  logic signed [PW-1:0]          prod_q;
  logic signed [AW-1:0]          acc_q;
  logic signed [STATE_WIDTH-1:0] w_q;
  logic signed [STATE_WIDTH-1:0] d1_q;
  logic signed [STATE_WIDTH-1:0] d2_q;
  logic [DAC_W-1:0]              dac_q;
  logic                          out_valid_q;

  logic signed [SAMPLE_W:0]      lr_sum;
  logic signed [SAMPLE_W:0]      lr_adj;
  logic signed [MUL_P_W-1:0]     vol_mag;
  logic [Q_W-1:0]                quot;
  logic signed [Q_W:0]           quot_s;
  logic signed [Q_W:0]           scaled;
  logic signed [SAMPLE_W-1:0]    scaled_sat;
  logic [Q_W-SAMPLE_W+1:0]       scaled_hi;
  logic signed [STATE_WIDTH-1:0] z_sel;
  logic signed [COEF_W-1:0]      coef_sel;
  logic signed [PW-1:0]          p_ext;
  logic signed [PW-1:0]          term_p;
  logic signed [AW-1:0]          p_acc;
  logic signed [AW-1:0]          acc_sum;
  logic [AW-STATE_WIDTH:0]       w_hi;
  logic signed [STATE_WIDTH-1:0] w_sat;
  logic signed [AW-1:0]          acc_rnd;
  logic signed [AW-1:0]          filt_t;
  logic [AW-SAMPLE_W:0]          filt_hi;
  logic signed [SAMPLE_W-1:0]    filt_sat;
  logic signed [SAMPLE_W-1:0]    samp_rnd;
  logic signed [SAMPLE_W-1:0]    samp_div;

  // Mean of left and right, truncated toward zero.
  assign lr_sum = {left_i[SAMPLE_W-1], left_i} + {right_i[SAMPLE_W-1], right_i};
  assign lr_adj = lr_sum + {{SAMPLE_W{1'b0}}, lr_sum[SAMPLE_W]};

  // Magnitude of mean times volume, the dividend of the divide by ten.
  assign vol_mag = mul_p_i[MUL_P_W-1] ? -mul_p_i : mul_p_i;

  // Quotient of the reciprocal multiply, signed back and saturated to 16 bits.
  assign quot      = mul_p_i[DIV_SHIFT+Q_W-1:DIV_SHIFT];
  assign quot_s    = $signed({1'b0, quot});
  assign scaled    = sign_q ? -quot_s : quot_s;
  assign scaled_hi = scaled[Q_W:SAMPLE_W-1];
  always_comb begin
    if ((&scaled_hi) || !(|scaled_hi)) begin
      scaled_sat = scaled[SAMPLE_W-1:0];
    end else begin
      scaled_sat = scaled[Q_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                               : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

  // Coefficient and state word of the current filter product.
  always_comb begin
    case (ctrl_i.term)
      TERM_B1D1: begin
        coef_sel = cfg_i.b1;
        z_sel    = d1_q;
      end
      TERM_B2D2: begin
        coef_sel = cfg_i.b2;
        z_sel    = d2_q;
      end
      TERM_A1D1: begin
        coef_sel = cfg_i.a1;
        z_sel    = d1_q;
      end
      TERM_A2D2: begin
        coef_sel = cfg_i.a2;
        z_sel    = d2_q;
      end
      default: begin
        coef_sel = cfg_i.a0;
        z_sel    = w_q;
      end
    endcase
  end

  // Operands of the shared multiplier.
  always_comb begin
    case (ctrl_i.mul_sel)
      MUL_VOL: begin
        mul_a_o = {{(MUL_OP_W-SAMPLE_W){mean_q[SAMPLE_W-1]}}, mean_q};
        mul_b_o = {{(MUL_OP_W-VOL_W){1'b0}}, cfg_i.volume};
      end
      MUL_DIV: begin
        mul_a_o = {{(MUL_OP_W-MAG_W){1'b0}}, vol_mag[MAG_W-1:0]};
        mul_b_o = RECIP_TEN;
      end
      MUL_LO: begin
        mul_a_o = {{(MUL_OP_W-COEF_W){coef_sel[COEF_W-1]}}, coef_sel};
        mul_b_o = {{(MUL_OP_W-SPLIT){1'b0}}, z_sel[SPLIT-1:0]};
      end
      MUL_HI: begin
        mul_a_o = {{(MUL_OP_W-COEF_W){coef_sel[COEF_W-1]}}, coef_sel};
        mul_b_o = {{(MUL_OP_W-ZH_W){z_sel[STATE_WIDTH-1]}}, z_sel[STATE_WIDTH-1:SPLIT]};
      end
      default: begin
        mul_a_o = '0;
        mul_b_o = '0;
      end
    endcase
  end

  // Full product, floored by the coefficient fraction, into the accumulator.
  assign p_ext   = {{(PW-MUL_P_W){mul_p_i[MUL_P_W-1]}}, mul_p_i};
  assign term_p  = prod_q >>> COEF_FRAC_BITS;
  assign p_acc   = {{(AW-PW){term_p[PW-1]}}, term_p};
  assign acc_sum = ctrl_i.acc_sub ? (acc_q - p_acc) : (acc_q + p_acc);

  // New w saturates to the state range.
  assign w_hi = acc_sum[AW-1:STATE_WIDTH-1];
  always_comb begin
    if ((&w_hi) || !(|w_hi)) begin
      w_sat = acc_sum[STATE_WIDTH-1:0];
    end else begin
      w_sat = acc_sum[AW-1] ? {1'b1, {(STATE_WIDTH-1){1'b0}}}
                            : {1'b0, {(STATE_WIDTH-1){1'b1}}};
    end
  end

  // Filter output: drop the state fraction toward zero, saturate to 16 bits.
  assign acc_rnd = acc_q + {{(AW-STATE_FRAC){1'b0}}, {STATE_FRAC{acc_q[AW-1]}}};
  assign filt_t  = acc_rnd >>> STATE_FRAC;
  assign filt_hi = filt_t[AW-1:SAMPLE_W-1];
  always_comb begin
    if ((&filt_hi) || !(|filt_hi)) begin
      filt_sat = filt_t[SAMPLE_W-1:0];
    end else begin
      filt_sat = filt_t[AW-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                              : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

  // DAC code: sample over sixteen toward zero, offset to midscale.
  assign samp_rnd = sample_q + {{(SAMPLE_W-DAC_SHIFT){1'b0}}, {DAC_SHIFT{sample_q[SAMPLE_W-1]}}};
  assign samp_div = samp_rnd >>> DAC_SHIFT;

  // Working registers of the current frame.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_in) begin
      mean_q <= lr_adj[SAMPLE_W:1];
    end
    if (ctrl_i.sign_cap) begin
      sign_q <= mul_p_i[MUL_P_W-1];
    end
    if (ctrl_i.scale_done) begin
      sample_q <= scaled_sat;
      acc_q    <= {{(AW-SAMPLE_W){scaled_sat[SAMPLE_W-1]}}, scaled_sat} <<< STATE_FRAC;
    end else if (ctrl_i.take_w) begin
      w_q   <= w_sat;
      acc_q <= '0;
    end else if (ctrl_i.acc_step) begin
      acc_q <= acc_sum;
    end else if (ctrl_i.finish) begin
      sample_q <= filt_sat;
    end
    if (ctrl_i.prod_init) begin
      prod_q <= p_ext;
    end else if (ctrl_i.prod_add) begin
      prod_q <= prod_q + (p_ext <<< SPLIT);
    end
    if (ctrl_i.out_load) begin
      dac_q <= samp_div[DAC_W-1:0] + DAC_MID;
    end
  end

  // Delay line of the biquad advances once per filtered frame.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1_q <= '0;
      d2_q <= '0;
    end else if (ctrl_i.finish) begin
      d1_q <= w_q;
      d2_q <= d1_q;
    end
  end

  // Output register holds a beat until it is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!dac_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_free_o  = !out_valid_q || !dac_stall_i;
  assign dac_valid_o = out_valid_q;
  assign dac_code_o  = dac_q;

  `SDBD_ASSERT_NEXT(a_delay_hold, clk_i, rst_ni, !ctrl_i.finish, $stable(d1_q) && $stable(d2_q), "delay state changed outside the end of a filtered frame")
  `SDBD_ASSERT_NEXT(a_out_load, clk_i, rst_ni, ctrl_i.out_load, out_valid_q, "loaded result is not presented")
  `SDBD_ASSERT_SAME(a_w_after_feedback, clk_i, rst_ni, ctrl_i.take_w, ctrl_i.term == TERM_B2D2, "w taken before both feedback products")

endmodule

`default_nettype wire

/* design/stereo_downmix_biquad_dac.sv */
// One frame at a time: a new frame is taken once the last result is in the output register.
// With boost, 5 filter products share the single 25x25 multiplier, each done as a low half,
// a high half, a sum and an accumulate step.
// A finished result waits in the output register while the next frame is taken.
// Reset (asynchronous, active low) loads the register defaults and clears the delay state.
`default_nettype none
`include "stereo_downmix_biquad_dac_defines.svh"

module stereo_downmix_biquad_dac #(
  parameter int COEF_FRAC_BITS = sdbd_pkg::COEF_FRAC_BITS_DEF,
  parameter int STATE_WIDTH    = sdbd_pkg::STATE_WIDTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [sdbd_pkg::SAMPLE_W-1:0] left_sample_i,
  input  logic signed [sdbd_pkg::SAMPLE_W-1:0] right_sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [sdbd_pkg::DAC_W-1:0]           dac_code_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [sdbd_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [sdbd_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import sdbd_pkg::*;

  sdbd_cfg_t                 cfg;
  sdbd_ctrl_t                ctrl;
  logic                      busy;
  logic                      out_free;
  logic signed [MUL_OP_W-1:0] mul_a;
  logic signed [MUL_OP_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0]  mul_p;

  // Configuration registers.
  sdbd_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Frame sequencer.
  sdbd_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .boost_i    (cfg.boost),
    .out_free_i (out_free),
    .busy_o     (busy),
    .ctrl_o     (ctrl)
  );

  // Shared multiplier.
  sdbd_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // Datapath and output register.
  sdbd_dp #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .STATE_WIDTH    (STATE_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .cfg_i       (cfg),
    .left_i      (left_sample_i),
    .right_i     (right_sample_i),
    .dac_stall_i (out_stall_i),
    .dac_valid_o (out_valid_o),
    .dac_code_o  (dac_code_o),
    .out_free_o  (out_free),
    .mul_a_o     (mul_a),
    .mul_b_o     (mul_b),
    .mul_p_i     (mul_p)
  );

  // The input side stalls while a frame is being worked on.
  assign in_stall_o = busy;

  `SDBD_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "input not stalled after a frame was accepted")

endmodule

`default_nettype wire

/* sim/stereo_downmix_biquad_dac_tb.sv */
// Self-checking testbench for the stereo downmix, bass-boost biquad and DAC code block.
`timescale 1ns / 1ps

module stereo_downmix_biquad_dac_tb;
  import sdbd_pkg::*;

  localparam int FRAC_BITS   = COEF_FRAC_BITS_DEF;
  localparam int STATE_W     = STATE_WIDTH_DEF;
  localparam int SETTLE      = 32;
  localparam int HOLD_CYCLES = 300;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 62;

  // Index outside the register map; writes to it must have no effect.
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
  } frame_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] left = '0;
  logic signed [SAMPLE_W-1:0] right = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [DAC_W-1:0]           dac_code;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;

  // Frames waiting to be offered, and DAC codes waiting to come out.
  frame_t           frame_q[$];
  logic [DAC_W-1:0] dac_exp_q[$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int err_count = 0;
  logic hold_arm = 1'b0;
  int hold_left = 0;

  // Shadow copy of the registers and the filter delay line.
  logic [VOL_W-1:0]          m_volume = VOLUME_RST;
  logic                      m_boost = BOOST_RST;
  logic signed [COEF_W-1:0]  m_a0 = A0_RST;
  logic signed [COEF_W-1:0]  m_a1 = A1_RST;
  logic signed [COEF_W-1:0]  m_a2 = A2_RST;
  logic signed [COEF_W-1:0]  m_b1 = B1_RST;
  logic signed [COEF_W-1:0]  m_b2 = B2_RST;
  logic signed [STATE_W-1:0] m_d1 = '0;
  logic signed [STATE_W-1:0] m_d2 = '0;

  stereo_downmix_biquad_dac u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .left_sample_i  (left),
    .right_sample_i (right),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .dac_code_o     (dac_code),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always #4 clk = ~clk;

  // Saturate to a signed range of the given width.
  function automatic longint clip(longint v, int width);
    longint hi;
    hi = (longint'(1) <<< (width - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // Coefficient times state, floored back to the state format.
  function automatic longint coef_mul(logic signed [COEF_W-1:0] c, longint z);
    return (longint'(c) * z) >>> FRAC_BITS;
  endfunction

  // Expected DAC code for one frame; advances the delay line when boost is on.
  function automatic logic [DAC_W-1:0] downmix_to_dac(logic signed [SAMPLE_W-1:0] l,
                                                      logic signed [SAMPLE_W-1:0] r);
    longint mono;
    longint w;
    longint acc;
    mono = (longint'(l) + longint'(r)) / 2;
    mono = clip(mono * longint'(m_volume) / 10, SAMPLE_W);
    if (m_boost) begin
      w = clip((mono <<< STATE_FRAC) - coef_mul(m_b1, longint'(m_d1))
               - coef_mul(m_b2, longint'(m_d2)), STATE_W);
      acc = coef_mul(m_a0, w) + coef_mul(m_a1, longint'(m_d1)) + coef_mul(m_a2, longint'(m_d2));
      mono = clip(acc / 256, SAMPLE_W);
      m_d2 = m_d1;
      m_d1 = STATE_W'(w);
    end
    return DAC_W'(mono / 16 + 2048);
  endfunction

  // Mirror a register write in the shadow copy.
  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_VOLUME: m_volume = data[VOL_W-1:0];
      REG_BOOST:  m_boost = data[0];
      REG_A0:     m_a0 = data[COEF_W-1:0];
      REG_A1:     m_a1 = data[COEF_W-1:0];
      REG_A2:     m_a2 = data[COEF_W-1:0];
      REG_B1:     m_b1 = data[COEF_W-1:0];
      REG_B2:     m_b2 = data[COEF_W-1:0];
      default: ;
    endcase
  endfunction

  // Mix of full-range, quiet and extreme sample values.
  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(9))
      0, 1: return SAMPLE_W'($signed($urandom_range(600)) - 300);
      2: begin
        case ($urandom_range(3))
          0: return 16'sh8000;
          1: return 16'sh7fff;
          2: return 16'sh0000;
          default: return 16'shffff;
        endcase
      end
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Sender: offers queued frames and predicts each one as its beat is taken.
  always @(posedge clk) begin : drv
    frame_t nxt;
    logic   offer;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        dac_exp_q.push_back(downmix_to_dac(left, right));
      end
      if (!in_valid || !in_stall) begin
        offer = (frame_q.size() != 0) && ($urandom_range(99) >= send_idle_pct);
        if (offer) begin
          nxt = frame_q.pop_front();
          left <= nxt.left;
          right <= nxt.right;
        end
        in_valid <= offer;
      end
    end
  end

  // Long receiver hold-off, counted here once armed.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_arm) begin
      hold_left <= HOLD_CYCLES;
    end
  end

  // Receiver: checks every output beat against the oldest expected code.
  always @(posedge clk) begin : mon
    logic [DAC_W-1:0] want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (dac_exp_q.size() == 0) begin
          $error("dac_code: expected none, actual %0d", dac_code);
          err_count++;
        end else begin
          want = dac_exp_q.pop_front();
          if (dac_code !== want) begin
            $error("dac_code: expected %0d, actual %0d", want, dac_code);
            err_count++;
          end
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
    end
  end

  // One beat on the configuration channel.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_reg(idx, data);
  endtask

  // Wait until every frame has been sent and every code has come back.
  task automatic drain();
    while (frame_q.size() != 0 || in_valid || dac_exp_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic push_frame(int l, int r);
    frame_q.push_back('{left: SAMPLE_W'(l), right: SAMPLE_W'(r)});
  endtask

  task automatic push_random(int n);
    logic signed [SAMPLE_W-1:0] l;
    for (int k = 0; k < n; k++) begin
      l = rand_sample();
      // Now and then a correlated pair, as real stereo material mostly is.
      if ($urandom_range(3) == 0) push_frame(l, l);
      else push_frame(l, rand_sample());
    end
  endtask

  // Load all five coefficients: defaults, full random, extremes or near the defaults.
  task automatic load_coefs(int kind);
    logic signed [COEF_W-1:0] rst_val[5];
    logic signed [COEF_W-1:0] c;
    rst_val = '{A0_RST, A1_RST, A2_RST, B1_RST, B2_RST};
    for (int j = 0; j < 5; j++) begin
      case (kind)
        0: c = rst_val[j];
        1: c = COEF_W'($urandom);
        2: c = $urandom_range(1) ? 24'sh7fffff : 24'sh800000;
        default: c = rst_val[j] + COEF_W'($signed($urandom_range(8191)) - 4096);
      endcase
      write_reg(CFG_IDX_W'(int'(REG_A0) + j), CFG_DATA_W'(c));
    end
  endtask

  initial begin : run
    logic [VOL_W-1:0] vol;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Reset settings in bypass: rounding toward zero and full-scale frames.
    push_frame(0, 0);
    push_frame(32767, 32767);
    push_frame(-32768, -32768);
    push_frame(-1, 0);
    push_frame(-3, 0);
    push_frame(1, 2);
    push_frame(-32768, 32767);
    push_frame(32767, -32768);
    drain();

    // Volume above ten saturates the scaled sample; a stray index changes nothing.
    write_reg(REG_VOLUME, CFG_DATA_W'(15));
    write_reg(REG_NONE, CFG_DATA_W'(1));
    push_frame(32767, 32767);
    push_frame(-32768, -32768);
    push_frame(20000, 20000);
    push_frame(-21846, -21846);
    drain();

    // Boost on with the reset coefficients: impulse and its ringing.
    write_reg(REG_VOLUME, CFG_DATA_W'(10));
    write_reg(REG_BOOST, CFG_DATA_W'(1));
    push_frame(32767, 32767);
    repeat (4) push_frame(0, 0);
    push_frame(-32768, -32768);
    push_frame(-32768, -32768);
    push_frame(0, 0);
    drain();

    // Extreme coefficients drive the state and the output into saturation.
    write_reg(REG_A0, CFG_DATA_W'(24'sh7fffff));
    write_reg(REG_A1, CFG_DATA_W'(24'sh800000));
    write_reg(REG_A2, CFG_DATA_W'(24'sh7fffff));
    write_reg(REG_B1, CFG_DATA_W'(24'sh800000));
    write_reg(REG_B2, CFG_DATA_W'(24'sh7fffff));
    repeat (3) push_frame(32767, 32767);
    repeat (2) push_frame(-32768, -32768);
    drain();

    // Random phases, each with its own settings and idle pattern.
    for (int i = 0; i < RAND_PHASES; i++) begin
      case (i % 4)
        0: vol = 4'd10;
        1: vol = 4'd15;
        2: vol = 4'd0;
        default: vol = VOL_W'($urandom_range(1, 15));
      endcase
      write_reg(REG_VOLUME, CFG_DATA_W'(vol));
      write_reg(REG_BOOST, CFG_DATA_W'(i % 3 != 2));
      load_coefs((i + 1) % 4);
      case (i % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 48; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 48; end
        default: begin send_idle_pct = 38; stall_pct = 38; end
      endcase
      if (i == 0) begin
        // Receiver holds off while the sender keeps offering, so the block backs up.
        push_random(PHASE_ITEMS);
        @(posedge clk);
        hold_arm <= 1'b1;
        @(posedge clk);
        hold_arm <= 1'b0;
      end else if (i == 4) begin
        // Sender pauses mid-phase until every code has come back.
        push_random(PHASE_ITEMS / 2);
        drain();
        push_random(PHASE_ITEMS - PHASE_ITEMS / 2);
      end else begin
        push_random(PHASE_ITEMS);
      end
      drain();
    end

    if (err_count == 0 && dac_exp_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #4_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

/* sim.f */
+incdir+design
design/sdbd_pkg.sv
design/sdbd_regs.sv
design/sdbd_mul.sv
design/sdbd_seq.sv
design/sdbd_dp.sv
design/stereo_downmix_biquad_dac.sv
sim/stereo_downmix_biquad_dac_tb.sv
